// ===== hw/rtl/keyed_cache_lru_fifo_expiry_defines.svh =====
// Assertion helpers for the cache block
`ifndef KEYED_CACHE_LRU_FIFO_EXPIRY_DEFINES_SVH
`define KEYED_CACHE_LRU_FIFO_EXPIRY_DEFINES_SVH

// property that holds in the cycle after a condition
`define KC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

// property that holds in the same cycle
`define KC_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

`endif

// ===== hw/rtl/kc_pkg.sv =====
`default_nettype none
package kc_pkg;
   localparam int DEPTH_DEF = 16;
   localparam int KEY_BITS_DEF = 32;
   localparam int VALUE_BITS_DEF = 32;
   localparam int TIME_BITS_DEF = 32;
   localparam int OP_BITS = 2;
   localparam int MAX_BITS = 5;
   localparam int CNT_BITS = 32;
   localparam int CSR_BITS = 5;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUT = 2'd0,
      OP_GET = 2'd1,
      OP_ERASE = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic {
      CSR_USE_LRU = 1'b0,
      CSR_MAX_ENTRIES = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVICT,
      ST_EXEC,
      ST_RESP
   } state_type;
endpackage
`default_nettype wire

// ===== hw/rtl/kc_front.sv =====
`default_nettype none
// Accepts requests into a two-entry queue.
module kc_front #(
   parameter int KEY_BITS = kc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = kc_pkg::VALUE_BITS_DEF,
   parameter int TIME_BITS = kc_pkg::TIME_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [kc_pkg::OP_BITS-1:0] req_opcode,
   input wire logic [KEY_BITS-1:0] req_entry_key,
   input wire logic [VALUE_BITS-1:0] req_entry_value,
   input wire logic [TIME_BITS-1:0] req_expiry_time,
   input wire logic [TIME_BITS-1:0] req_now_time,
   output logic q_valid,
   input wire logic q_pop,
   output kc_pkg::op_type q_op,
   output logic [KEY_BITS-1:0] q_key,
   output logic [VALUE_BITS-1:0] q_value,
   output logic [TIME_BITS-1:0] q_expiry,
   output logic [TIME_BITS-1:0] q_now
);
   import kc_pkg::*;
   localparam int W = OP_BITS + KEY_BITS + VALUE_BITS + 2*TIME_BITS;

   logic [W-1:0] buf_ff [2];
   logic [W-1:0] head;
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign head = buf_ff[rd_ff];
   assign q_op = op_type'(head[W-1 -: OP_BITS]);
   assign {q_key, q_value, q_expiry, q_now} = head[W-OP_BITS-1:0];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
      rd_in = rd_ff ^ q_pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) begin
         buf_ff[wr_ff] <= {req_opcode, req_entry_key, req_entry_value,
                           req_expiry_time, req_now_time};
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/kc_back.sv =====
`default_nettype none
`include "keyed_cache_lru_fifo_expiry_defines.svh"
// Executes one request on the slot table.
module kc_back #(
   parameter int DEPTH = kc_pkg::DEPTH_DEF,
   parameter int KEY_BITS = kc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = kc_pkg::VALUE_BITS_DEF,
   parameter int TIME_BITS = kc_pkg::TIME_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic use_lru,
   input wire logic [kc_pkg::MAX_BITS-1:0] max_entries,
   input wire logic q_valid,
   output logic q_pop,
   input wire kc_pkg::op_type q_op,
   input wire logic [KEY_BITS-1:0] q_key,
   input wire logic [VALUE_BITS-1:0] q_value,
   input wire logic [TIME_BITS-1:0] q_expiry,
   input wire logic [TIME_BITS-1:0] q_now,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic rsp_found,
   output logic [VALUE_BITS-1:0] rsp_value_out,
   output logic [TIME_BITS-1:0] rsp_expiry_out,
   output logic [kc_pkg::CNT_BITS-1:0] rsp_hit_total,
   output logic [kc_pkg::CNT_BITS-1:0] rsp_access_total,
   output logic [$clog2(DEPTH+1)-1:0] rsp_entry_total
);
   import kc_pkg::*;
   localparam int IB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CB = $clog2(DEPTH+1);

   state_type state_ff, state_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [KEY_BITS-1:0] key_ff [DEPTH];
   logic [VALUE_BITS-1:0] val_ff [DEPTH];
   logic [TIME_BITS-1:0] exp_ff [DEPTH];
   logic [IB-1:0] rank_ff [DEPTH], rank_in [DEPTH];
   logic [CB-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] hit_ff, hit_in, acc_ff, acc_in;
   logic [DEPTH-1:0] match_ff, match_in;
   logic hit_any_ff, hit_any_in;
   logic [IB-1:0] hidx_ff, hidx_in;
   logic [CB-1:0] limit;
   logic [DEPTH-1:0] oldest;
   logic [IB-1:0] free_idx;
   logic write_en;
   logic found_in;
   logic [VALUE_BITS-1:0] vout_in;
   logic [TIME_BITS-1:0] eout_in;
   logic rsp_load;
   logic drop_en;
   logic [IB-1:0] drop_idx;
   logic bump_en;

   always_comb begin
      limit = CB'(DEPTH);
      if (max_entries != '0 && 32'(max_entries) <= DEPTH) begin
         limit = CB'(max_entries);
      end
      match_in = '0;
      hit_any_in = 1'b0;
      hidx_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == q_key);
         if (match_in[i]) begin
            hit_any_in = 1'b1;
            hidx_in = IB'(i);
         end
      end
      free_idx = '0;
      for (int i = DEPTH-1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = IB'(i);
      end
      for (int i = 0; i < DEPTH; i++) begin
         oldest[i] = valid_ff[i] && (rank_ff[i] == '0);
      end
   end

   // Next state, slot updates and result
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      rank_in = rank_ff;
      count_in = count_ff;
      hit_in = hit_ff;
      acc_in = acc_ff;
      q_pop = 1'b0;
      write_en = 1'b0;
      found_in = 1'b0;
      vout_in = '0;
      eout_in = '0;
      rsp_load = 1'b0;
      drop_en = 1'b0;
      drop_idx = hidx_ff;
      bump_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // match and hidx were captured last cycle
            found_in = hit_any_ff;
            unique case (q_op)
               OP_PUT: begin
                  if (hit_any_ff) drop_en = 1'b1;
                  state_in = ST_EVICT;
               end
               OP_GET: begin
                  if (hit_any_ff) begin
                     if (exp_ff[hidx_ff] != '0 && exp_ff[hidx_ff] < q_now) begin
                        found_in = 1'b0;
                        drop_en = 1'b1;
                     end else begin
                        vout_in = val_ff[hidx_ff];
                        bump_en = use_lru;
                        hit_in = hit_ff + 1'b1;
                        acc_in = acc_ff + 1'b1;
                     end
                  end else begin
                     acc_in = acc_ff + 1'b1;
                  end
                  state_in = ST_RESP;
               end
               default: begin
                  if (hit_any_ff) begin
                     drop_en = 1'b1;
                     if (q_op == OP_REMOVE) begin
                        vout_in = val_ff[hidx_ff];
                        eout_in = exp_ff[hidx_ff];
                     end
                  end
                  state_in = ST_RESP;
               end
            endcase
            if (state_in == ST_RESP) rsp_load = 1'b1;
         end
         ST_EVICT: begin
            found_in = rsp_found;
            if (count_ff >= limit) begin
               drop_en = 1'b1;
               for (int i = 0; i < DEPTH; i++) begin
                  if (oldest[i]) drop_idx = IB'(i);
               end
            end else begin
               write_en = 1'b1;
               rank_in[free_idx] = IB'(count_ff);
               valid_in[free_idx] = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_load = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               q_pop = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (drop_en) begin
         valid_in[drop_idx] = 1'b0;
         count_in = count_ff - 1'b1;
         for (int i = 0; i < DEPTH; i++) begin
            if (valid_ff[i] && rank_ff[i] > rank_ff[drop_idx]) rank_in[i] = rank_ff[i] - 1'b1;
         end
      end
      if (bump_en) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (valid_ff[i] && rank_ff[i] > rank_ff[hidx_ff]) rank_in[i] = rank_ff[i] - 1'b1;
         end
         rank_in[hidx_ff] = IB'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
         hit_ff <= '0;
         acc_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
         hit_ff <= hit_in;
         acc_ff <= acc_in;
         if (rsp_load) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
      rank_ff <= rank_in;
      if (state_ff == ST_IDLE) begin
         match_ff <= match_in;
         hit_any_ff <= hit_any_in;
         hidx_ff <= hidx_in;
      end
      if (write_en) begin
         key_ff[free_idx] <= q_key;
         val_ff[free_idx] <= q_value;
         exp_ff[free_idx] <= q_expiry;
      end
      // hold the put's replace flag until the slot write
      if (rsp_load) begin
         rsp_found <= found_in;
         rsp_value_out <= vout_in;
         rsp_expiry_out <= eout_in;
         rsp_hit_total <= hit_in;
         rsp_access_total <= acc_in;
         rsp_entry_total <= count_in;
      end else if (state_ff == ST_EXEC) begin
         rsp_found <= found_in;
      end
   end

   `KC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CB'(DEPTH), "count above depth")
   `KC_ASSERT_NOW(a_match_onehot, clock, reset, state_ff == ST_EXEC, $onehot0(match_ff), "duplicate key")
   `KC_ASSERT_NEXT(a_hit_le_acc, clock, reset, state_ff == ST_EXEC && hit_in != hit_ff, acc_ff != $past(acc_ff), "hit without access")
   `KC_ASSERT_NOW(a_pop_resp, clock, reset, q_pop, rsp_valid, "pop without result")
endmodule
`default_nettype wire

// ===== hw/rtl/keyed_cache_lru_fifo_expiry.sv =====
`default_nettype none
// Fully associative key/value cache with per-entry expiry and LRU or FIFO
// replacement. A front queue of two requests takes items while the back
// executes one at a time: an idle cycle registers the lookup and the next
// cycle applies the update. Put then passes through an evict state that
// drops the oldest entry while the count is at the limit (at most one in
// steady state, more right after the entry limit is lowered) and then writes
// the slot. Every operation ends in a result state, held while the result
// is stalled and left when it is accepted. The result register holds the
// answer while new requests keep queueing. Configure only while idle.
module keyed_cache_lru_fifo_expiry #(
   parameter int DEPTH = kc_pkg::DEPTH_DEF,
   parameter int KEY_BITS = kc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = kc_pkg::VALUE_BITS_DEF,
   parameter int TIME_BITS = kc_pkg::TIME_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write,
   input wire logic csr_index,
   input wire logic [kc_pkg::CSR_BITS-1:0] csr_data,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [kc_pkg::OP_BITS-1:0] req_opcode,
   input wire logic [KEY_BITS-1:0] req_entry_key,
   input wire logic [VALUE_BITS-1:0] req_entry_value,
   input wire logic [TIME_BITS-1:0] req_expiry_time,
   input wire logic [TIME_BITS-1:0] req_now_time,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic rsp_found,
   output logic [VALUE_BITS-1:0] rsp_value_out,
   output logic [TIME_BITS-1:0] rsp_expiry_out,
   output logic [kc_pkg::CNT_BITS-1:0] rsp_hit_total,
   output logic [kc_pkg::CNT_BITS-1:0] rsp_access_total,
   output logic [$clog2(DEPTH+1)-1:0] rsp_entry_total
);
   import kc_pkg::*;

   logic lru_ff;
   logic [MAX_BITS-1:0] max_ff;
   logic q_valid, q_pop;
   op_type q_op;
   logic [KEY_BITS-1:0] q_key;
   logic [VALUE_BITS-1:0] q_value;
   logic [TIME_BITS-1:0] q_expiry, q_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         lru_ff <= 1'b1;
         max_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_USE_LRU: lru_ff <= csr_data[0];
            CSR_MAX_ENTRIES: max_ff <= csr_data[MAX_BITS-1:0];
            default: ;
         endcase
      end
   end

   kc_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS), .TIME_BITS(TIME_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_entry_key,
      .req_entry_value, .req_expiry_time, .req_now_time,
      .q_valid, .q_pop, .q_op, .q_key, .q_value, .q_expiry, .q_now
   );

   kc_back #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
             .TIME_BITS(TIME_BITS)) u_back (
      .clock, .reset, .use_lru(lru_ff), .max_entries(max_ff),
      .q_valid, .q_pop, .q_op, .q_key, .q_value, .q_expiry, .q_now,
      .rsp_valid, .rsp_stall, .rsp_found, .rsp_value_out, .rsp_expiry_out,
      .rsp_hit_total, .rsp_access_total, .rsp_entry_total
   );
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
   import kc_pkg::*;

   localparam int SLOTS = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic        found;
      logic [31:0] value;
      logic [31:0] expiry;
      logic [31:0] hits;
      logic [31:0] accesses;
      logic [4:0]  entries;
   } cache_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   csr_idx_type csr_index = CSR_USE_LRU;
   logic [CSR_BITS-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   op_type req_opcode = OP_PUT;
   logic [31:0] req_entry_key = '0;
   logic [31:0] req_entry_value = '0;
   logic [31:0] req_expiry_time = '0;
   logic [31:0] req_now_time = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic [31:0] rsp_value_out;
   logic [31:0] rsp_expiry_out;
   logic [31:0] rsp_hit_total;
   logic [31:0] rsp_access_total;
   logic [4:0] rsp_entry_total;

   keyed_cache_lru_fifo_expiry u_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_entry_key(req_entry_key), .req_entry_value(req_entry_value),
      .req_expiry_time(req_expiry_time), .req_now_time(req_now_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
      .rsp_value_out(rsp_value_out), .rsp_expiry_out(rsp_expiry_out),
      .rsp_hit_total(rsp_hit_total), .rsp_access_total(rsp_access_total),
      .rsp_entry_total(rsp_entry_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the cache
   logic        shadow_valid [SLOTS];
   logic [31:0] shadow_key [SLOTS];
   logic [31:0] shadow_value [SLOTS];
   logic [31:0] shadow_expiry [SLOTS];
   int          shadow_rank [SLOTS];
   logic [31:0] shadow_hits = '0;
   logic [31:0] shadow_accesses = '0;
   logic        shadow_lru = 1'b1;
   logic [4:0]  shadow_max = '0;

   cache_answer_type pending_answers [$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;
   logic [31:0] clock_now = 32'd1000;

   initial for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;

   function automatic int live_entries();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (shadow_valid[i]) n++;
      return n;
   endfunction

   function automatic int slot_of_key(logic [31:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int oldest_slot();
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_rank[i] == 0) return i;
      return -1;
   endfunction

   // invalidate and close the gap in the age order
   function automatic void evict_slot(int s);
      int r;
      r = shadow_rank[s];
      shadow_valid[s] = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
   endfunction

   function automatic void promote_slot(int s);
      int r;
      int n;
      r = shadow_rank[s];
      n = live_entries();
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
      shadow_rank[s] = n - 1;
   endfunction

   function automatic cache_answer_type lookup_and_update(op_type op, logic [31:0] k,
         logic [31:0] v, logic [31:0] e, logic [31:0] t);
      cache_answer_type a;
      int s;
      int limit;
      int o;
      a = '0;
      s = slot_of_key(k);
      case (op)
         OP_PUT: begin
            limit = int'(shadow_max);
            if (limit == 0 || limit > SLOTS) limit = SLOTS;
            if (s >= 0) begin
               a.found = 1'b1;
               evict_slot(s);
            end
            while (live_entries() >= limit) begin
               o = oldest_slot();
               if (o < 0) break;
               evict_slot(o);
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (!shadow_valid[i]) begin
                  shadow_rank[i] = live_entries();
                  shadow_valid[i] = 1'b1;
                  shadow_key[i] = k;
                  shadow_value[i] = v;
                  shadow_expiry[i] = e;
                  break;
               end
            end
         end
         OP_GET: begin
            if (s < 0) shadow_accesses++;
            else if (shadow_expiry[s] != 0 && shadow_expiry[s] < t) evict_slot(s);
            else begin
               a.found = 1'b1;
               a.value = shadow_value[s];
               if (shadow_lru) promote_slot(s);
               shadow_hits++;
               shadow_accesses++;
            end
         end
         default: begin
            if (s >= 0) begin
               a.found = 1'b1;
               if (op == OP_REMOVE) begin
                  a.value = shadow_value[s];
                  a.expiry = shadow_expiry[s];
               end
               evict_slot(s);
            end
         end
      endcase
      a.hits = shadow_hits;
      a.accesses = shadow_accesses;
      a.entries = 5'(live_entries());
      return a;
   endfunction

   task automatic send_item(op_type op, logic [31:0] k, logic [31:0] v,
         logic [31:0] e, logic [31:0] t);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_opcode = op;
      req_entry_key = k;
      req_entry_value = v;
      req_expiry_time = e;
      req_now_time = t;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_answers.push_back(lookup_and_update(op, k, v, e, t));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [4:0] d);
      drain();
      csr_index = idx;
      csr_data = d;
      csr_write = 1'b1;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == CSR_USE_LRU) shadow_lru = d[0];
      else shadow_max = d;
   endtask

   always @(negedge clock)
      rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      cache_answer_type want;
      cache_answer_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_found, rsp_value_out, rsp_expiry_out, rsp_hit_total,
                rsp_access_total, rsp_entry_total};
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_answers.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_basic_ops();
      send_item(OP_PUT, 32'd1, 32'h1111, 32'd0, 32'd10);
      send_item(OP_GET, 32'd1, 32'd0, 32'd0, 32'd10);
      send_item(OP_GET, 32'd9, 32'd0, 32'd0, 32'd10);
      send_item(OP_PUT, 32'd2, 32'h2222, 32'd100, 32'd10);
      send_item(OP_GET, 32'd2, 32'd0, 32'd0, 32'd100);
      send_item(OP_GET, 32'd2, 32'd0, 32'd0, 32'd101);
      send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_GET, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_item(OP_PUT, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_item(OP_ERASE, 32'd77, 32'd0, 32'd0, 32'd0);
      send_item(OP_REMOVE, 32'd77, 32'd0, 32'd0, 32'd0);
      send_item(OP_ERASE, 32'd1, 32'd0, 32'd0, 32'd0);
      send_item(OP_REMOVE, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
      send_item(OP_PUT, 32'd0, 32'h5A5A, 32'd7, 32'd0);
   endtask

   task automatic test_eviction_order();
      write_csr(CSR_MAX_ENTRIES, 5'd2);
      send_item(OP_PUT, 32'd3, 32'd3, 32'd0, 32'd0);
      send_item(OP_GET, 32'd0, 32'd0, 32'd0, 32'd0);
      send_item(OP_PUT, 32'd4, 32'd4, 32'd0, 32'd0);
      send_item(OP_GET, 32'd3, 32'd0, 32'd0, 32'd0);
      write_csr(CSR_USE_LRU, 5'd0);
      send_item(OP_GET, 32'd4, 32'd0, 32'd0, 32'd0);
      send_item(OP_PUT, 32'd5, 32'd5, 32'd0, 32'd0);
      send_item(OP_GET, 32'd4, 32'd0, 32'd0, 32'd0);
      send_item(OP_REMOVE, 32'd5, 32'd0, 32'd0, 32'd0);
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(9) == 0) return $urandom;
      return $urandom_range(0, 23);
   endfunction

   task automatic test_random_traffic(int count);
      op_type op;
      logic [31:0] e;
      logic [31:0] t;
      for (int n = 0; n < count; n++) begin
         clock_now += $urandom_range(0, 20);
         op = op_type'($urandom_range(9) < 4 ? OP_PUT : $urandom_range(1, 3));
         case ($urandom_range(3))
            0: e = 32'd0;
            1: e = $urandom;
            default: e = clock_now + $urandom_range(0, 150);
         endcase
         t = ($urandom_range(19) == 0) ? $urandom : clock_now;
         send_item(op, pick_key(), $urandom, e, t);
      end
   endtask

   task automatic test_wait_for_empty();
      send_item(OP_PUT, 32'd6, 32'd6, 32'd0, 32'd0);
      send_item(OP_PUT, 32'd7, 32'd7, 32'd0, 32'd0);
      drain();
      send_item(OP_GET, 32'd6, 32'd0, 32'd0, 32'd0);
   endtask

   initial begin
      logic [4:0] max_plan [6];
      int timeout;
      max_plan = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd5, 5'd17};
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_basic_ops();
      test_eviction_order();
      for (int seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 63 : 0;
         recv_idle_pct = (seg < 2) ? 63 : (seg < 4) ? 11 : 0;
         write_csr(CSR_USE_LRU, seg[0] ? 5'd0 : 5'd1);
         write_csr(CSR_MAX_ENTRIES, max_plan[seg]);
         test_random_traffic(188);
         if (seg == 3) test_wait_for_empty();
      end
      req_valid = 1'b0;
      timeout = 0;
      while (pending_answers.size() != 0 && timeout < WATCHDOG_LIMIT) begin
         @(negedge clock);
         timeout++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/kc_pkg.sv
hw/rtl/kc_front.sv
hw/rtl/kc_back.sv
hw/rtl/keyed_cache_lru_fifo_expiry.sv
dv/tb.sv
